[src/ssw_pkg.sv]
package ssw_pkg;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] END_TYPE = 8'd127;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_END      = 2'd2;
  localparam logic [1:0] ST_EARLY    = 2'd3;

  localparam logic REG_WANTED_TYPE = 1'b0;
  localparam logic REG_MAX_LENGTH  = 1'b1;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN,
    PH_FORMATTED,
    PH_STR_FIRST,
    PH_STR
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] struct_offset;
    logic [7:0]  formatted_length;
    logic [15:0] total_length;
    logic [7:0]  string_count;
    logic        last;
  } result_t;

endpackage

[src/smbios_structure_walker_top.sv]
// A result is offered in the cycle after the transfer of the byte that closes it.
// Throughput: one byte per cycle while the result queue has room; a byte yields at most two results.
// Results wait in a four-entry queue; bytes are taken while at least two entries are free.
// Reset is synchronous: registers that have a reset return to their reset values and the next byte
// starts a walk as though restart were set.
module smbios_structure_walker_top import ssw_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]             wanted_type;
  logic [15:0]            max_length;
  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] byte_offset, offset_eff, offset_next;
  logic [OFFSET_BITS-1:0] struct_start, struct_start_next;
  logic [7:0]             current_type, current_type_next;
  logic [7:0]             header_length, header_length_next;
  logic [15:0]            bytes_in_struct, bytes_in_struct_next;
  logic                   prev_was_zero, prev_was_zero_next;
  logic [7:0]             strings_seen, strings_seen_next;
  logic                   halted, halted_eff;
  phase_t                 phase_eff;

  logic    accept, work, done, wanted, halt_set, has_found, has_final;
  result_t found_res, final_res;
  logic [1:0] n_res;

  result_t              queue [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 pop;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LENGTH) ? {16'd0, max_length} : {24'd0, wanted_type};

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_type <= 8'd0;
      max_length  <= 16'hFFFF;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MAX_LENGTH) begin
        max_length <= pwdata[15:0];
      end else begin
        wanted_type <= pwdata[7:0];
      end
    end
  end

  assign item_ready = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign accept     = item_valid && item_ready;
  assign phase_eff  = item.restart ? PH_TYPE : phase;
  assign halted_eff = item.restart ? 1'b0 : halted;
  assign offset_eff = item.restart ? '0 : byte_offset;
  assign work       = accept && !halted_eff;

  always_comb begin
    offset_next          = (offset_eff == '1) ? offset_eff : offset_eff + 1'b1;
    phase_next           = phase_eff;
    struct_start_next    = struct_start;
    current_type_next    = current_type;
    header_length_next   = header_length;
    bytes_in_struct_next = bytes_in_struct;
    prev_was_zero_next   = prev_was_zero;
    strings_seen_next    = strings_seen;
    done                 = 1'b0;
    unique case (phase_eff)
      PH_TYPE: begin
        struct_start_next    = offset_eff;
        current_type_next    = item.data_byte;
        header_length_next   = 8'd0;
        bytes_in_struct_next = 16'd1;
        strings_seen_next    = 8'd0;
        prev_was_zero_next   = 1'b0;
        phase_next           = PH_LEN;
      end
      PH_LEN: begin
        header_length_next   = item.data_byte;
        bytes_in_struct_next = 16'd2;
        phase_next           = (item.data_byte <= 8'd2) ? PH_STR_FIRST : PH_FORMATTED;
      end
      PH_FORMATTED: begin
        bytes_in_struct_next = sat_inc16(bytes_in_struct);
        if (bytes_in_struct_next >= {8'd0, header_length}) begin
          phase_next = PH_STR_FIRST;
        end
      end
      PH_STR_FIRST: begin
        bytes_in_struct_next = sat_inc16(bytes_in_struct);
        prev_was_zero_next   = (item.data_byte == 8'd0);
        phase_next           = PH_STR;
      end
      PH_STR: begin
        bytes_in_struct_next = sat_inc16(bytes_in_struct);
        if (item.data_byte == 8'd0) begin
          if (prev_was_zero) begin
            done = 1'b1;
          end else if (strings_seen != 8'hFF) begin
            strings_seen_next = strings_seen + 8'd1;
          end
          prev_was_zero_next = 1'b1;
        end else begin
          prev_was_zero_next = 1'b0;
        end
      end
      default: begin
        phase_next = PH_TYPE;
      end
    endcase

    wanted    = (current_type_next == wanted_type);
    has_found = 1'b0;
    has_final = 1'b0;
    halt_set  = 1'b0;
    found_res = '{status: ST_FOUND, struct_offset: 16'(struct_start_next),
                  formatted_length: header_length_next,
                  total_length: bytes_in_struct_next,
                  string_count: strings_seen_next, last: 1'b0};
    final_res = found_res;
    if (done) begin
      phase_next = PH_TYPE;
      if (wanted && (bytes_in_struct_next >= max_length)) begin
        has_final        = 1'b1;
        final_res.status = ST_TOO_LONG;
        final_res.last   = 1'b1;
      end else begin
        has_found = wanted;
        if (current_type_next == END_TYPE) begin
          has_final        = 1'b1;
          final_res.status = ST_END;
          final_res.last   = 1'b1;
        end else if (item.end_of_data) begin
          has_final = 1'b1;
          final_res = '{status: ST_END, struct_offset: 16'(offset_next),
                        formatted_length: 8'd0, total_length: 16'd0,
                        string_count: 8'd0, last: 1'b1};
        end
      end
    end else if (item.end_of_data) begin
      has_final        = 1'b1;
      final_res.status = ST_EARLY;
      final_res.last   = 1'b1;
    end
    halt_set = has_final;
    n_res    = {1'b0, has_found} + {1'b0, has_final};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      byte_offset <= '0;
      halted      <= 1'b0;
    end else if (accept) begin
      halted <= halted_eff || (!halted_eff && halt_set);
      if (!halted_eff) begin
        phase       <= phase_next;
        byte_offset <= offset_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      struct_start    <= struct_start_next;
      current_type    <= current_type_next;
      header_length   <= header_length_next;
      bytes_in_struct <= bytes_in_struct_next;
      prev_was_zero   <= prev_was_zero_next;
      strings_seen    <= strings_seen_next;
    end
  end

  assign pop          = result_valid && result_ready;
  assign result_valid = (count != '0);
  assign result       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (work && (n_res != 2'd0)) begin
      queue[wr_ptr] <= has_found ? found_res : final_res;
      if (n_res == 2'd2) begin
        queue[wr_ptr + RES_PTR_W'(1)] <= final_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (work) begin
        wr_ptr <= wr_ptr + RES_PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + (work ? RES_CNT_W'(n_res) : '0) - RES_CNT_W'(pop);
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && halted && !item.restart && !pop) |=> (count == $past(count)))
    else $error("halted walk produced a result");

  a_eod_halts: assert property (@(posedge clk) disable iff (rst)
    (work && item.end_of_data) |=> halted)
    else $error("walk did not halt at end of data");

  a_offset_grows: assert property (@(posedge clk) disable iff (rst)
    !(accept && item.restart) |=> (byte_offset >= $past(byte_offset)))
    else $error("byte offset went backwards without restart");

endmodule
